### rtl/core/asp_pkg.sv
// Shared types, constants and helpers for the all-different singleton propagation core.
package asp_pkg;

    // Fixed field widths of the command and result words, and the singleton queue depth.
    localparam int ROW_W = 6;
    localparam int DOM_W = 64;
    localparam int CNT_W = 7;
    localparam int QUEUE_DEPTH = 64;

    // Operation codes of a command word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Sequencer states; the cells also read them to know what a sweep does.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_PICK,
        S_ELIM,
        S_EMIT
    } t_state;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        t_state             state;
        logic               inject;
        logic [ROW_W-1:0]   pv;
        logic [DOM_W-1:0]   bit_mask;
        logic [CNT_W-1:0]   rows;
        logic               clr_marks;
        logic               load_en;
        logic [ROW_W-1:0]   load_row;
        logic [DOM_W-1:0]   load_bits;
    } t_sweep_ctl;

    // Report of one cell, and the merged report of the whole chain.
    typedef struct packed {
        logic               fail;
        logic               enq;
        logic               drive;
        logic               assigned;
        logic [DOM_W-1:0]   domain;
    } t_cell_rpt;

    // True when exactly one bit of the mask is set.
    function automatic logic is_single(logic [DOM_W-1:0] d);
        return (d != '0) && ((d & (d - DOM_W'(1))) == '0);
    endfunction

endpackage

### rtl/core/asp_cell.sv
// One row cell: holds the row's domain and assigned mark and passes the sweep token on.
module asp_cell import asp_pkg::*; #(
    parameter int IDX = 0,
    parameter int TV  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sweep_ctl  i_ctl,
    input  logic        i_tok,
    output logic        o_tok,
    output t_cell_rpt   o_rpt
);

    logic [TV-1:0] r_dom;
    logic [TV-1:0] n_dom;
    logic          r_mark;
    logic          n_mark;
    logic          r_tok;

    logic [TV-1:0] bit_l;
    logic [TV-1:0] pruned;
    logic          is_pv;
    logic          is_last;
    logic          hit;
    logic          fail;
    logic          enq;
    logic          drive;

    assign bit_l   = i_ctl.bit_mask[TV-1:0];
    assign pruned  = r_dom & ~bit_l;
    assign hit     = |(r_dom & bit_l);
    assign is_pv   = (i_ctl.pv == ROW_W'(IDX));
    assign is_last = (i_ctl.rows == CNT_W'(IDX + 1));

    // Per-sweep action of the token holder, or of the popped row in a pick.
    always_comb begin
        fail   = 1'b0;
        enq    = 1'b0;
        drive  = 1'b0;
        n_dom  = r_dom;
        n_mark = r_mark;
        case (i_ctl.state)
            S_SCAN: begin
                if (r_tok) begin
                    if (r_dom == '0) begin
                        fail = 1'b1;
                    end else if (is_single(DOM_W'(r_dom))) begin
                        enq    = 1'b1;
                        n_mark = 1'b1;
                    end
                end
            end
            S_ELIM: begin
                if (r_tok && !is_pv && hit) begin
                    n_dom = pruned;
                    if (pruned == '0) begin
                        fail = 1'b1;
                    end else if (is_single(DOM_W'(pruned))) begin
                        enq    = 1'b1;
                        n_mark = 1'b1;
                    end
                end
            end
            S_PICK: begin
                drive = is_pv;
            end
            S_EMIT: begin
                drive = r_tok;
            end
            default: begin
            end
        endcase
        if (i_ctl.load_en && (i_ctl.load_row == ROW_W'(IDX))) begin
            n_dom = i_ctl.load_bits[TV-1:0];
        end
        if (i_ctl.clr_marks) begin
            n_mark = 1'b0;
        end
    end

    // Domain storage has no reset; it is undefined until loaded.
    always_ff @(posedge i_clk) begin
        r_dom <= n_dom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_mark <= n_mark;
            r_tok  <= i_tok;
        end
    end

    // A contradiction stops the sweep, and the last row in use ends it.
    assign o_tok = r_tok && !fail && !is_last;

    assign o_rpt.fail     = fail;
    assign o_rpt.enq      = enq;
    assign o_rpt.drive    = drive;
    assign o_rpt.assigned = drive & r_mark;
    assign o_rpt.domain   = drive ? DOM_W'(r_dom) : '0;

endmodule

### rtl/core/asp_chain.sv
// Row of cells with the token links between neighbors and the merged report bus.
module asp_chain import asp_pkg::*; #(
    parameter int ROWS = 64,
    parameter int TV   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sweep_ctl  i_ctl,
    output t_cell_rpt   o_rpt
);

    logic [ROWS:0]      tok;
    t_cell_rpt          rpt [ROWS];
    logic [ROWS-1:0]    fail_v;
    logic [ROWS-1:0]    enq_v;
    logic [ROWS-1:0]    drive_v;
    logic [ROWS-1:0]    asg_v;
    logic [ROWS-1:0]    col [DOM_W];

    // The sequencer injects the token into row zero.
    assign tok[0] = i_ctl.inject;

    for (genvar i = 0; i < ROWS; i++) begin : g_cell
        asp_cell #(
            .IDX (i),
            .TV  (TV)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_tok   (tok[i]),
            .o_tok   (tok[i+1]),
            .o_rpt   (rpt[i])
        );
        assign fail_v[i]  = rpt[i].fail;
        assign enq_v[i]   = rpt[i].enq;
        assign drive_v[i] = rpt[i].drive;
        assign asg_v[i]   = rpt[i].assigned;
        for (genvar b = 0; b < DOM_W; b++) begin : g_col
            assign col[b][i] = rpt[i].domain[b];
        end
    end

    // At most one cell reports at a time, so the bus is a plain OR.
    assign o_rpt.fail     = |fail_v;
    assign o_rpt.enq      = |enq_v;
    assign o_rpt.drive    = |drive_v;
    assign o_rpt.assigned = |asg_v;
    for (genvar b = 0; b < DOM_W; b++) begin : g_or
        assign o_rpt.domain[b] = |col[b];
    end

endmodule

### rtl/core/asp_ctrl.sv
// Run sequencer: command decode, singleton queue, sweep control and result register.
module asp_ctrl import asp_pkg::*; #(
    parameter int ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_operation,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [DOM_W-1:0]    i_domain_bits,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data,
    output t_sweep_ctl          o_ctl,
    input  t_cell_rpt           i_rpt,
    output logic                o_strobe,
    output logic [ROW_W-1:0]    o_out_row,
    output logic [DOM_W-1:0]    o_out_domain,
    output logic                o_assigned,
    output logic                o_success,
    output logic                o_last_row
);

    localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(ROWS);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cfg;
    logic [CNT_W-1:0]   rows_n;
    logic [ROW_W-1:0]   r_pos;
    logic [ROW_W-1:0]   n_pos;
    logic [CNT_W-1:0]   r_head;
    logic [CNT_W-1:0]   n_head;
    logic [CNT_W-1:0]   r_tail;
    logic [CNT_W-1:0]   n_tail;
    logic               r_ok;
    logic               n_ok;
    logic [DOM_W-1:0]   r_bit;
    logic [DOM_W-1:0]   n_bit;
    logic [ROW_W-1:0]   queue_mem [QUEUE_DEPTH];
    logic [ROW_W-1:0]   r_qdata;
    logic               q_we;
    logic               q_re;
    logic               inject;
    logic               load_en;
    logic               clr_marks;
    logic               pos_last;
    logic               r_o_strobe;
    logic [ROW_W-1:0]   r_o_row;
    logic [DOM_W-1:0]   r_o_dom;
    logic               r_o_asg;
    logic               r_o_ok;
    logic               r_o_last;

    // Row count in use: saturated to the cell count, zero taken as one.
    always_comb begin
        if (r_cfg > ROW_LIMIT) begin
            rows_n = ROW_LIMIT;
        end else if (r_cfg == '0) begin
            rows_n = CNT_W'(1);
        end else begin
            rows_n = r_cfg;
        end
    end

    // The row count is only taken while no run is in flight.
    assign pos_last    = ((CNT_W'(r_pos) + CNT_W'(1)) == rows_n);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);

    // Next state and sweep control.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos + ROW_W'(1);
        n_head    = r_head;
        n_tail    = r_tail;
        n_ok      = r_ok;
        n_bit     = r_bit;
        q_we      = 1'b0;
        q_re      = 1'b0;
        inject    = 1'b0;
        load_en   = 1'b0;
        clr_marks = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_RUN) begin
                        clr_marks = 1'b1;
                        inject    = 1'b1;
                        n_pos     = '0;
                        n_head    = '0;
                        n_tail    = '0;
                        n_ok      = 1'b1;
                        n_state   = S_SCAN;
                    end else begin
                        load_en = 1'b1;
                    end
                end
            end
            S_SCAN, S_ELIM: begin
                if (i_rpt.fail) begin
                    n_ok    = 1'b0;
                    inject  = 1'b1;
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else begin
                    if (i_rpt.enq && !r_tail[CNT_W-1]) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + CNT_W'(1);
                    end
                    if (pos_last) begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    inject  = 1'b1;
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else begin
                    q_re    = 1'b1;
                    n_head  = r_head + CNT_W'(1);
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // The popped row must still hold exactly one value.
                inject = 1'b1;
                n_pos  = '0;
                if (is_single(i_rpt.domain) && (CNT_W'(r_qdata) < rows_n)) begin
                    n_bit   = i_rpt.domain;
                    n_state = S_ELIM;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (pos_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, row position, queue pointers, status and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CNT_W'(64);
            r_pos   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ok    <= n_ok;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    // Singleton queue: one push per cycle in row order, registered pop.
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[r_tail[ROW_W-1:0]] <= r_pos;
        end
        if (q_re) begin
            r_qdata <= queue_mem[r_head[ROW_W-1:0]];
        end
    end

    // Broadcast word to the cells.
    assign o_ctl.state     = r_state;
    assign o_ctl.inject    = inject;
    assign o_ctl.pv        = r_qdata;
    assign o_ctl.bit_mask  = r_bit;
    assign o_ctl.rows      = rows_n;
    assign o_ctl.clr_marks = clr_marks;
    assign o_ctl.load_en   = load_en;
    assign o_ctl.load_row  = i_row_index;
    assign o_ctl.load_bits = i_domain_bits;

    // Result register: one word per row during emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= (r_state == S_EMIT) && i_rpt.drive;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row  <= r_pos;
        r_o_dom  <= i_rpt.domain;
        r_o_asg  <= i_rpt.assigned;
        r_o_ok   <= r_ok;
        r_o_last <= pos_last;
    end

    assign o_strobe     = r_o_strobe;
    assign o_out_row    = r_o_row;
    assign o_out_domain = r_o_dom;
    assign o_assigned   = r_o_asg;
    assign o_success    = r_o_ok;
    assign o_last_row   = r_o_last;

endmodule

### rtl/core/alldiff_singleton_propagation_core.sv
// Top level of the all-different singleton propagation core.
//
//  Channel   | Signals                                          | Handshake
//  ----------+--------------------------------------------------+---------------------------
//  command   | i_operation, i_row_index, i_domain_bits          | i_start && !o_busy
//  config    | i_cfg_data (rows in use)                         | i_cfg_valid && o_cfg_ready
//  result    | o_out_row, o_out_domain, o_assigned, o_success,  | o_strobe, one cycle,
//            | o_last_row                                       | cannot be stalled
//
// A run keeps o_busy high while the token walks the cell row once for the scan, once for
// every singleton row popped from the queue after a pop and a pick step, and once for
// emission after a final pop step, one cell per cycle. A contradiction cuts the walk
// short and goes straight to emission. Results come out one per cycle, in the cycle after
// the emission token passes their row, so the last one shows in the first idle cycle.
// The row count is written only while the core is idle. Reset clears control state and
// assigned marks; row domains are undefined until loaded.
module alldiff_singleton_propagation_core import asp_pkg::*; #(
    parameter int PATTERN_ROWS  = 64,
    parameter int TARGET_VALUES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_operation,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [DOM_W-1:0]    i_domain_bits,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data,
    output logic                o_strobe,
    output logic [ROW_W-1:0]    o_out_row,
    output logic [DOM_W-1:0]    o_out_domain,
    output logic                o_assigned,
    output logic                o_success,
    output logic                o_last_row
);

    // Only the first 64 rows are addressable by a load word.
    localparam int ROWS = (PATTERN_ROWS < QUEUE_DEPTH) ? PATTERN_ROWS : QUEUE_DEPTH;

    t_sweep_ctl ctl;
    t_cell_rpt  rpt;

    // Sequencer with queue and result register.
    asp_ctrl #(
        .ROWS (ROWS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_operation   (i_operation),
        .i_row_index   (i_row_index),
        .i_domain_bits (i_domain_bits),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_ctl         (ctl),
        .i_rpt         (rpt),
        .o_strobe      (o_strobe),
        .o_out_row     (o_out_row),
        .o_out_domain  (o_out_domain),
        .o_assigned    (o_assigned),
        .o_success     (o_success),
        .o_last_row    (o_last_row)
    );

    // Row of domain cells.
    asp_chain #(
        .ROWS (ROWS),
        .TV   (TARGET_VALUES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_rpt   (rpt)
    );

endmodule
